FILE: design/etc_pkg.sv
// Shared constants for the edge-triggered capture block.
// Used by edge_trigger_capture; depends on nothing else.
package etc_pkg;

  // Default sizes of the sample store, capture window and sample width.
  localparam int DEF_BUFFER_DEPTH = 2048;
  localparam int DEF_WINDOW       = 128;
  localparam int DEF_SAMPLE_BITS  = 12;

  // Width of the pair position field in a result.
  localparam int PAIR_INDEX_W = 6;

  // Input item kinds, carried in s_tuser.
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_LEVEL   = 1'b0;
  localparam logic REG_FALLING = 1'b1;

endpackage

FILE: design/etc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the sample store of edge_trigger_capture.
module etc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/edge_trigger_capture.sv
// Top level of the edge-triggered capture block: sample store, trigger search
// and window readout. Depends on etc_pkg and etc_ram.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tuser = command, s_tdata = sample
// m_*      out  m_tvalid/m_tready   m_tdata = first, second, pair index;
//                                   m_tuser = triggered, m_tlast = last pair
// cfg_*    in   cfg_wen             cfg_index selects level or edge direction
//
// A store transfer leaves the block ready, so stores can follow back to back.
// A capture primes the read, then searches backward with one store read per
// sample, at most BUFFER_DEPTH - WINDOW samples (the first compares a sample
// with itself), then reads out WINDOW/2 pairs, each by two reads, a latch and
// the transfer plus any wait on m_tready. The single read port of the store
// sets this order. After rst the store is cleared address by address with
// s_tready low; configuration writes are taken throughout.
module edge_trigger_capture #(
  parameter int BUFFER_DEPTH = etc_pkg::DEF_BUFFER_DEPTH,
  parameter int WINDOW       = etc_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS  = etc_pkg::DEF_SAMPLE_BITS,
  localparam int InDataW     = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OutDataW    = ((2 * SAMPLE_BITS + etc_pkg::PAIR_INDEX_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [InDataW-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic                   s_tuser,   // [0] command
  // Output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OutDataW-1:0]    m_tdata,   // sample_first, sample_second, pair_index, zeros
  output logic                   m_tuser,   // [0] triggered
  output logic                   m_tlast,
  // Configuration writes
  input  logic                   cfg_wen,
  input  logic                   cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data
);

  import etc_pkg::*;

  localparam int AddrW  = $clog2(BUFFER_DEPTH);
  localparam int Half   = WINDOW / 2;
  localparam int PairW  = $clog2(Half);
  localparam int Limit  = BUFFER_DEPTH - WINDOW;
  localparam int StepW  = $clog2(Limit);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_PRIME   = 3'd2;
  localparam logic [2:0] ST_SEARCH  = 3'd3;
  localparam logic [2:0] ST_FETCH_A = 3'd4;
  localparam logic [2:0] ST_FETCH_B = 3'd5;
  localparam logic [2:0] ST_LATCH   = 3'd6;
  localparam logic [2:0] ST_SHOW    = 3'd7;

  // Step back by d positions around the circular store.
  function automatic logic [AddrW-1:0] wrap_back(input logic [AddrW-1:0] x,
                                                 input logic [AddrW-1:0] d);
    logic [AddrW:0] sum;
    sum = {1'b0, x} + (AddrW+1)'(BUFFER_DEPTH) - {1'b0, d};
    if (x >= d) begin
      return x - d;
    end
    return sum[AddrW-1:0];
  endfunction

  // Step forward by one position around the circular store.
  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] x);
    if (x == AddrW'(BUFFER_DEPTH - 1)) begin
      return '0;
    end
    return x + 1'b1;
  endfunction

  logic [2:0]             state;
  logic [AddrW-1:0]       clr_addr;
  logic [AddrW-1:0]       newest;
  logic [AddrW-1:0]       newest_next;
  logic [AddrW-1:0]       start_addr;
  logic [AddrW-1:0]       pos;
  logic [AddrW-1:0]       cur_pos;
  logic [AddrW-1:0]       trig_addr;
  logic [StepW-1:0]       step;
  logic [PairW-1:0]       pair;
  logic [SAMPLE_BITS-1:0] level;
  logic                   falling;
  logic [SAMPLE_BITS-1:0] later;
  logic [SAMPLE_BITS-1:0] later_cmp;
  logic                   hit;
  logic                   found;
  logic                   timeout;
  logic [SAMPLE_BITS-1:0] out_first;
  logic [SAMPLE_BITS-1:0] out_second;
  logic [PAIR_INDEX_W-1:0] out_index;
  logic                   out_last;
  logic                   ram_wen;
  logic [AddrW-1:0]       ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   in_xfer;
  logic                   out_xfer;

  // Handshake and address arithmetic.
  assign s_tready    = (state == ST_IDLE);
  assign in_xfer     = s_tvalid && s_tready;
  assign out_xfer    = m_tvalid && m_tready;
  assign newest_next = wrap_inc(newest);
  assign start_addr  = wrap_back(newest, AddrW'(Half));

  // The clearing pass and sample stores share the write port.
  assign ram_wen   = (state == ST_CLEAR) || (in_xfer && (s_tuser == CMD_STORE));
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : newest_next;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : s_tdata[SAMPLE_BITS-1:0];

  etc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  // Crossing test on the sample just read; the first one is its own neighbor.
  always_comb begin
    later_cmp = (step == '0) ? ram_rdata : later;
    if (falling) begin
      hit = (later_cmp < level) && (ram_rdata >= level);
    end else begin
      hit = (later_cmp > level) && (ram_rdata <= level);
    end
    timeout   = (step == StepW'(Limit - 1));
    trig_addr = hit ? cur_pos : start_addr;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
      falling <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_LEVEL:   level   <= cfg_data;
        REG_FALLING: falling <= cfg_data[0];
        default:     level   <= level;
      endcase
    end
  end

  // Sequencer: clear, store, search backward, then read out pairs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      newest   <= '0;
      pos      <= '0;
      step     <= '0;
      pair     <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= wrap_inc(clr_addr);
          if (clr_addr == AddrW'(BUFFER_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_tuser == CMD_STORE) begin
              newest <= newest_next;
            end else begin
              pos   <= start_addr;
              step  <= '0;
              state <= ST_PRIME;
            end
          end
        end
        ST_PRIME: begin
          cur_pos <= pos;
          pos     <= wrap_back(pos, AddrW'(1));
          state   <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (hit || timeout) begin
            found <= hit;
            pos   <= wrap_back(trig_addr, AddrW'(Half - 1));
            pair  <= '0;
            state <= ST_FETCH_A;
          end else begin
            later   <= ram_rdata;
            cur_pos <= pos;
            pos     <= wrap_back(pos, AddrW'(1));
            step    <= step + 1'b1;
          end
        end
        ST_FETCH_A: begin
          pos   <= wrap_inc(pos);
          state <= ST_FETCH_B;
        end
        ST_FETCH_B: begin
          out_first <= ram_rdata;
          pos       <= wrap_inc(pos);
          state     <= ST_LATCH;
        end
        ST_LATCH: begin
          out_second <= ram_rdata;
          out_index  <= PAIR_INDEX_W'(pair);
          out_last   <= (pair == PairW'(Half - 1));
          state      <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_xfer) begin
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              pair  <= pair + 1'b1;
              state <= ST_FETCH_A;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result port.
  assign m_tvalid = (state == ST_SHOW);
  assign m_tdata  = OutDataW'({out_index, out_second, out_first});
  assign m_tuser  = found;
  assign m_tlast  = out_last;

  // The block never takes input while a result is waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  // The last flag marks exactly the final pair position.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (out_index == PAIR_INDEX_W'(Half - 1))))
    else $error("last flag does not match pair position");

  // After the final pair is taken, the block returns to accepting input.
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("capture did not end after the final pair");

  // A store transfer advances the newest pointer by one position.
  a_store_adv: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (s_tuser == CMD_STORE)) |=> (newest == $past(newest_next)))
    else $error("newest pointer did not advance on a store");

endmodule

FILE: test/etc_capture_checker.sv
`timescale 1ns / 100ps
// Checker for edge_trigger_capture: watches the input, output and configuration ports,
// predicts each capture window and compares every output transfer with it.
// Depends on etc_pkg for sizes, command codes and register indexes.
module etc_capture_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  input  logic [((etc_pkg::DEF_SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic s_tuser,
  input  logic m_tvalid,
  input  logic m_tready,
  input  logic [((2 * etc_pkg::DEF_SAMPLE_BITS + etc_pkg::PAIR_INDEX_W + 7) / 8) * 8 - 1:0]
               m_tdata,
  input  logic m_tuser,
  input  logic m_tlast,
  input  logic cfg_wen,
  input  logic cfg_index,
  input  logic [etc_pkg::DEF_SAMPLE_BITS-1:0] cfg_data,
  output int   pending_pairs,
  output int   failures
);

  import etc_pkg::*;

  localparam int Depth         = DEF_BUFFER_DEPTH;
  localparam int HalfWin       = DEF_WINDOW / 2;
  localparam int SampleW       = DEF_SAMPLE_BITS;
  localparam int PtrW          = $clog2(Depth);
  localparam int SearchSteps   = Depth - DEF_WINDOW;
  localparam int LevelAtReset  = 2048;
  localparam int ReportMax     = 10;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [PtrW-1:0]    ptr_t;

  typedef struct packed {
    sample_t                 first;
    sample_t                 second;
    logic [PAIR_INDEX_W-1:0] index;
    logic                    triggered;
    logic                    last_pair;
  } pair_t;

  // Shadow copy of the circular store, its write pointer and the trigger setup.
  sample_t sample_mem [Depth];
  ptr_t    newest_ptr;
  sample_t level_reg;
  logic    falling_reg;

  // Pairs still owed by the block, oldest first.
  pair_t window_pairs [$];

  // True when the edge lies between the examined sample and the one after it.
  function automatic bit is_crossing(sample_t cur, sample_t later);
    if (falling_reg) return (later < level_reg) && (cur >= level_reg);
    return (later > level_reg) && (cur <= level_reg);
  endfunction

  // Walk backward from half a window before the newest sample, then queue the
  // window around the trigger as pairs in time order.
  function automatic void capture_window();
    ptr_t    start_ptr;
    ptr_t    pos;
    ptr_t    base;
    sample_t later;
    sample_t cur;
    bit      found;
    int      step;
    pair_t   p;
    start_ptr = newest_ptr - ptr_t'(HalfWin);
    pos       = start_ptr;
    later     = sample_mem[pos];
    found     = 1'b0;
    step      = 0;
    while (!found && step < SearchSteps) begin
      cur = sample_mem[pos];
      if (is_crossing(cur, later)) begin
        found = 1'b1;
      end else begin
        later = cur;
        pos   = pos - 1'b1;
        step++;
      end
    end
    // A search that runs out falls back to the start position.
    if (!found) pos = start_ptr;
    base = pos - ptr_t'(HalfWin - 1);
    for (int k = 0; k < HalfWin; k++) begin
      p.first     = sample_mem[ptr_t'(base + ptr_t'(2 * k))];
      p.second    = sample_mem[ptr_t'(base + ptr_t'(2 * k + 1))];
      p.index     = k[PAIR_INDEX_W-1:0];
      p.triggered = found;
      p.last_pair = (k == HalfWin - 1);
      window_pairs.push_back(p);
    end
  endfunction

  // Count a failure; only the first few are printed.
  task automatic report(input string msg);
    failures++;
    if (failures <= ReportMax) $display("%0t ns: %s", $time, msg);
  endtask

  // Results are compared before new items are predicted, since a result at this
  // edge always belongs to an earlier capture.
  always @(posedge clk) begin : monitor
    pair_t got;
    pair_t want;
    if (rst) begin
      for (int i = 0; i < Depth; i++) sample_mem[i] = '0;
      newest_ptr  = '0;
      level_reg   = sample_t'(LevelAtReset);
      falling_reg = 1'b0;
      window_pairs.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.first     = m_tdata[SampleW-1:0];
        got.second    = m_tdata[2*SampleW-1:SampleW];
        got.index     = m_tdata[2*SampleW +: PAIR_INDEX_W];
        got.triggered = m_tuser;
        got.last_pair = m_tlast;
        if (window_pairs.size() == 0) begin
          report($sformatf("unexpected transfer: first=%0d second=%0d index=%0d trig=%0b last=%0b",
                           got.first, got.second, got.index, got.triggered, got.last_pair));
        end else begin
          want = window_pairs.pop_front();
          if (got.first !== want.first || got.second !== want.second ||
              got.index !== want.index || got.triggered !== want.triggered ||
              got.last_pair !== want.last_pair) begin
            report($sformatf({"pair mismatch: expected first=%0d second=%0d index=%0d ",
                              "trig=%0b last=%0b, got first=%0d second=%0d index=%0d ",
                              "trig=%0b last=%0b"},
                             want.first, want.second, want.index, want.triggered,
                             want.last_pair, got.first, got.second, got.index,
                             got.triggered, got.last_pair));
          end
        end
      end
      if (cfg_wen) begin
        if (cfg_index == REG_LEVEL) level_reg = cfg_data;
        else falling_reg = cfg_data[0];
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_STORE) begin
          newest_ptr             = newest_ptr + 1'b1;
          sample_mem[newest_ptr] = s_tdata[SampleW-1:0];
        end else begin
          capture_window();
        end
      end
    end
    pending_pairs <= window_pairs.size();
  end

endmodule

FILE: test/tb_edge_trigger_capture.sv
`timescale 1ns / 100ps
// Testbench top for edge_trigger_capture: clock, reset, stimulus and the verdict.
// Depends on etc_pkg, the block itself and etc_capture_checker.
module tb_edge_trigger_capture;
  import etc_pkg::*;

  localparam int SampleW      = DEF_SAMPLE_BITS;
  localparam int InDataW      = ((SampleW + 7) / 8) * 8;
  localparam int OutDataW     = ((2 * SampleW + PAIR_INDEX_W + 7) / 8) * 8;
  localparam int SampleMax    = (1 << SampleW) - 1;
  localparam int HoldCycles   = 3000;
  localparam int SettleCycles = 16;
  localparam int PhaseItems   = 30;
  localparam int PhaseCount   = 6;

  typedef enum int {SHAPE_NOISE, SHAPE_RAMP, SHAPE_SQUARE, SHAPE_FLAT} wave_shape_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                s_tuser   = CMD_STORE;
  logic                m_tready  = 1'b0;
  logic                cfg_wen   = 1'b0;
  logic                cfg_index = REG_LEVEL;
  logic [SampleW-1:0]  cfg_data  = '0;
  logic                s_tready;
  logic                m_tvalid;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  int   pending_pairs;
  int   failures;
  int   items_sent    = 0;
  int   send_idle_pct = 19;
  int   recv_idle_pct = 79;
  logic hold_req      = 1'b0;

  always #1 clk = ~clk;

  edge_trigger_capture i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  etc_capture_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending_pairs(pending_pairs),
    .failures     (failures)
  );

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #10_000_000;
    $display("edge_trigger_capture regression: fail");
    $finish;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int  hold_left;
    bit  hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item, with random idle cycles first, and wait for its transfer.
  task automatic send_item(input logic cmd, input logic [SampleW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= InDataW'(value);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every pair is out and the block is idle.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pairs != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write both trigger registers on consecutive cycles.
  task automatic set_trigger(input logic [SampleW-1:0] level, input logic falling);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_LEVEL;
    cfg_data  <= level;
    @(posedge clk);
    cfg_index <= REG_FALLING;
    cfg_data  <= {{(SampleW-1){1'b0}}, falling};
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // A burst of samples shaped like a signal, followed by a capture.
  task automatic send_waveform();
    int          n;
    int          lo;
    int          hi;
    int          period;
    int          v;
    wave_shape_t shape;
    n      = $urandom_range(60, 8);
    lo     = $urandom_range(SampleMax);
    hi     = $urandom_range(SampleMax);
    period = $urandom_range(8, 1);
    shape  = wave_shape_t'($urandom_range(3));
    for (int k = 0; k < n; k++) begin
      case (shape)
        SHAPE_NOISE:  v = $urandom_range(SampleMax);
        SHAPE_RAMP:   v = lo + ((hi - lo) * k) / (n - 1);
        SHAPE_SQUARE: v = ((k / period) % 2) ? lo : hi;
        default:      v = lo;
      endcase
      send_item(CMD_STORE, v[SampleW-1:0]);
    end
    send_item(CMD_CAPTURE, SampleW'($urandom_range(SampleMax)));
  endtask

  // A few items of random kind, which breaks up the burst pattern.
  task automatic send_noise();
    int n;
    n = $urandom_range(4, 1);
    repeat (n) begin
      send_item(($urandom_range(2) == 0) ? CMD_CAPTURE : CMD_STORE,
                SampleW'($urandom_range(SampleMax)));
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Capture over the cleared store: no crossing, window wraps past index zero.
    // The receiver then holds off long enough for the block to stall its input.
    send_item(CMD_CAPTURE, SampleW'(SampleMax));
    hold_req <= 1'b1;
    send_item(CMD_STORE, SampleW'(SampleMax));
    send_item(CMD_STORE, '0);
    send_item(CMD_STORE, SampleW'(SampleMax));
    send_item(CMD_STORE, '0);
    send_item(CMD_STORE, SampleW'(2048));
    send_item(CMD_STORE, SampleW'(2047));
    send_item(CMD_STORE, SampleW'(2049));
    send_item(CMD_STORE, SampleW'(1));
    send_item(CMD_STORE, SampleW'(SampleMax - 1));
    send_item(CMD_STORE, SampleW'(12'haaa));
    send_item(CMD_STORE, SampleW'(12'h555));
    // Back-to-back captures; the window now holds the newest samples.
    send_item(CMD_CAPTURE, '0);
    send_item(CMD_CAPTURE, SampleW'(12'h5a5));

    // Random phases, each with its own trigger setup and idling pattern.
    for (int p = 0; p < PhaseCount; p++) begin
      int phase_start;
      settle();
      case (p)
        0:       set_trigger('0, 1'b0);
        1:       set_trigger(SampleW'(SampleMax), 1'b1);
        2:       set_trigger(SampleW'($urandom_range(SampleMax)), 1'b1);
        3:       set_trigger(SampleW'($urandom_range(SampleMax)), 1'b0);
        4:       set_trigger(SampleW'(SampleMax), 1'b0);
        default: set_trigger('0, 1'b1);
      endcase
      case (p / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct <= 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct <= 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if ($urandom_range(99) < 85) send_waveform();
        else send_noise();
      end
    end

    settle();
    if (failures == 0) begin
      $display("edge_trigger_capture regression: pass");
    end else begin
      $display("edge_trigger_capture regression: fail");
    end
    $finish;
  end

endmodule
